// ===== hw/rtl/trigger_step_sequencer_assert.svh =====
// assertion macros used by the trigger step sequencer top level
// needs nothing but a clock and an active-low reset at the point of use
`ifndef TRIGGER_STEP_SEQUENCER_ASSERT_SVH
`define TRIGGER_STEP_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tss_pkg.sv =====
// shared types, constants and the tempo numerator function
// used by every module of the trigger step sequencer; no dependencies
`default_nettype none

package tss_pkg;

    // sizing defaults for the top-level parameters
    localparam int unsigned STEPS_DEF  = 8;
    localparam int unsigned TRACKS_DEF = 3;

    // tempo arithmetic
    localparam int unsigned HALF_MAX  = 1000;
    localparam int unsigned HALF_SPAN = 950;
    localparam int unsigned POT_FULL  = 4095;
    localparam int unsigned POT_SHIFT = 12;
    localparam int unsigned NUM_W     = 22;
    localparam int unsigned HALF_W    = 10;

    // beat kinds on the slave tuser
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PRESS = 2'd1,
        KIND_TEMPO = 2'd2
    } t_kind;

    // one input beat as held in the input register
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       track;
        logic             wnr;
        logic [7:0]       bits;
        logic [NUM_W-1:0] numer;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [2:0]        gates;
        logic              clk_level;
        logic [2:0]        step;
        logic [7:0]        rb_bits;
        logic              rb_valid;
        logic [HALF_W-1:0] half;
    } t_result;

    // rounded-up division numerator: 950*sample + 4094
    function automatic logic [NUM_W-1:0] pot_numer(input logic [11:0] sample);
        logic [31:0] prod;
        prod = 32'(sample) * 32'(HALF_SPAN) + 32'(POT_FULL - 1);
        return prod[NUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trigger_step_sequencer.sv =====
// top level of the trigger step sequencer: input register, core, result register
// depends on tss_pkg, tss_core, tss_tempo and trigger_step_sequencer_assert.svh
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+---------------
//  slave   | in  | track 2, write_not_read 1, program_bits 8,      | kind 2
//          |     | pot_sample 12, pad 1                            |
//  master  | out | track_gates 3, clock_level 1, current_step 3,   | readback_valid
//          |     | readback_bits 8, half_period_ms 10, pad 7       |
//
// every beat passes from slave to master through the input register, then through the
// core into the result register; one beat per cycle sustained while the master does not stall.
// the path from the input register to the result register (tempo divide by 4095
// and the state update) sets the cycle time.
// synchronous active-low reset clears both valid flags and all sequencer state.
// a master stall holds the result register, then the input register, then tready.
`default_nettype none

`include "trigger_step_sequencer_assert.svh"

module trigger_step_sequencer
    import tss_pkg::*;
#(
    parameter int unsigned STEPS  = STEPS_DEF,
    parameter int unsigned TRACKS = TRACKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // track, write_not_read, program_bits, pot_sample
    input  wire logic [1:0]  i_s_tuser,  // kind
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,  // track_gates, clock_level, current_step,
                                         // readback_bits, half_period_ms
    output logic             o_m_tuser   // readback_valid
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    in_acc;
    logic    adv;
    t_result core_res;

    // handshake: the core advances when the result register can take a beat
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload, tempo numerator formed on the way in
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item.kind  <= i_s_tuser;
            r_in_item.track <= i_s_tdata[1:0];
            r_in_item.wnr   <= i_s_tdata[2];
            r_in_item.bits  <= i_s_tdata[10:3];
            r_in_item.numer <= pot_numer(i_s_tdata[22:11]);
        end
    end

    tss_core #(
        .STEPS  (STEPS),
        .TRACKS (TRACKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    // master side packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.half, r_out.rb_bits, r_out.step,
                         r_out.clk_level, r_out.gates};
    assign o_m_tuser  = r_out.rb_valid;

    // checks
    `TSS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_item))
    `TSS_ASSERT_IMPL(a_half_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[24:15] >= 10'd50 && o_m_tdata[24:15] <= 10'd1000)
    `TSS_ASSERT_IMPL(a_gates_low, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[3], o_m_tdata[2:0] == 3'd0)
    `TSS_ASSERT_IMPL(a_rb_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[14:7] == 8'd0)

endmodule

`default_nettype wire

// ===== hw/rtl/tss_tempo.sv =====
// half-period from the tempo numerator: 1000 - numer / 4095
// the divide by 4095 is a shift-add estimate plus one correction; uses tss_pkg
`default_nettype none

module tss_tempo
    import tss_pkg::*;
(
    input  wire logic [NUM_W-1:0]  i_numer,
    output logic      [HALF_W-1:0] o_half
);

    logic [NUM_W:0]    sum;
    logic [NUM_W:0]    q0;
    logic [NUM_W:0]    prod;
    logic [NUM_W:0]    rem;
    logic [HALF_W-1:0] quot;

    // estimate never exceeds the true quotient and falls short by at most one
    always_comb begin
        sum  = (NUM_W+1)'(i_numer) + (NUM_W+1)'(i_numer >> POT_SHIFT);
        q0   = sum >> POT_SHIFT;
        prod = (q0 << POT_SHIFT) - q0;
        rem  = (NUM_W+1)'(i_numer) - prod;
        if (rem >= (NUM_W+1)'(POT_FULL)) begin
            quot = HALF_W'(q0) + HALF_W'(1);
        end else begin
            quot = HALF_W'(q0);
        end
        o_half = HALF_W'(HALF_MAX) - quot;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_core.sv =====
// sequencer state: patterns, step, tempo, millisecond countdown and levels
// applies one item per advance and shows the post-update result; uses tss_pkg
`default_nettype none

module tss_core
    import tss_pkg::*;
#(
    parameter int unsigned STEPS  = STEPS_DEF,
    parameter int unsigned TRACKS = TRACKS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_adv,
    input  wire t_item   i_item,
    output t_result      o_result
);

    localparam int unsigned STEP_W = $clog2(STEPS);
    localparam int unsigned TRK_IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    logic [STEPS-1:0]  r_pattern [TRACKS];
    logic [STEPS-1:0]  n_pattern [TRACKS];
    logic [STEP_W-1:0] r_step, n_step;
    logic [HALF_W-1:0] r_half, n_half;
    logic [HALF_W-1:0] r_rem, n_rem;
    logic              r_beat, n_beat;
    logic [TRACKS-1:0] r_gates, n_gates;

    logic [HALF_W-1:0] tempo_half;
    logic [HALF_W-1:0] rem_dec;
    logic [TRACKS-1:0] step_gates;
    logic [TRK_IW-1:0] trk_idx;
    logic              trk_ok;
    logic [7:0]        rb_bits;
    logic              rb_valid;

    tss_tempo u_tempo (
        .i_numer (i_item.numer),
        .o_half  (tempo_half)
    );

    // gate pattern at the current step, one bit per track
    always_comb begin
        for (int t = 0; t < TRACKS; t++) begin
            step_gates[t] = r_pattern[t][r_step];
        end
    end

    assign trk_idx = TRK_IW'(i_item.track);
    assign trk_ok  = 32'(i_item.track) < TRACKS;
    assign rem_dec = (r_rem != '0) ? r_rem - HALF_W'(1) : r_rem;

    // next state for one item
    always_comb begin
        n_pattern = r_pattern;
        n_step    = r_step;
        n_half    = r_half;
        n_rem     = r_rem;
        n_beat    = r_beat;
        n_gates   = r_gates;
        rb_bits   = '0;
        rb_valid  = 1'b0;
        unique case (i_item.kind)
            KIND_TICK: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    if (!r_beat) begin
                        n_gates = step_gates;
                        n_beat  = 1'b1;
                        if (32'(r_step) == STEPS - 1) begin
                            n_step = '0;
                        end else begin
                            n_step = r_step + STEP_W'(1);
                        end
                    end else begin
                        n_gates = '0;
                        n_beat  = 1'b0;
                    end
                    n_rem = r_half;
                end
            end
            KIND_PRESS: begin
                if (trk_ok) begin
                    if (i_item.wnr) begin
                        n_pattern[trk_idx] = STEPS'(i_item.bits);
                    end else begin
                        rb_bits  = 8'(r_pattern[trk_idx]);
                        rb_valid = 1'b1;
                    end
                end
            end
            KIND_TEMPO: begin
                n_half = tempo_half;
            end
            default: begin
            end
        endcase
    end

    // result reflects the state after this item
    always_comb begin
        o_result.gates     = 3'(n_gates);
        o_result.clk_level = n_beat;
        o_result.step      = 3'(n_step);
        o_result.rb_bits   = rb_bits;
        o_result.rb_valid  = rb_valid;
        o_result.half      = n_half;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                r_pattern[t] <= '0;
            end
            r_step  <= '0;
            r_half  <= HALF_W'(HALF_MAX);
            r_rem   <= '0;
            r_beat  <= 1'b0;
            r_gates <= '0;
        end else if (i_adv) begin
            r_pattern <= n_pattern;
            r_step    <= n_step;
            r_half    <= n_half;
            r_rem     <= n_rem;
            r_beat    <= n_beat;
            r_gates   <= n_gates;
        end
    end

endmodule

`default_nettype wire
